// ----- hdl/sust_pkg.sv -----
package sust_pkg;

  // Default sizes of the table
  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned KEY_BITS_DEF    = 32;

  // Fixed widths of the channel fields
  localparam int unsigned CAP_W     = 9;
  localparam int unsigned KEY_IN_W  = 32;
  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned RANK_W    = 9;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_RANK   = 2'd2,
    ACT_READ   = 2'd3
  } sust_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_DUP    = 2'd2,
    ST_ABSENT = 2'd3
  } sust_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_RDATA,
    S_FINISH
  } sust_state_e;

endpackage

// ----- hdl/sust_if.sv -----
interface sust_req_if;
  logic                           valid;
  logic                           ready;
  logic [sust_pkg::ACTION_W-1:0]  action;
  logic [sust_pkg::KEY_IN_W-1:0]  key;
  logic [sust_pkg::SCORE_W-1:0]   score;
  logic [sust_pkg::POS_W-1:0]     position;

  modport source (output valid, action, key, score, position, input ready);
  modport sink   (input valid, action, key, score, position, output ready);
endinterface

interface sust_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sust_pkg::STATUS_W-1:0]  status;
  logic [sust_pkg::RANK_W-1:0]    rank;
  logic [sust_pkg::KEY_IN_W-1:0]  entry_key;
  logic [sust_pkg::SCORE_W-1:0]   entry_score;
  logic [sust_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, status, rank, entry_key, entry_score, entry_count,
                  input ready);
  modport sink   (input valid, status, rank, entry_key, entry_score, entry_count,
                  output ready);
endinterface

interface sust_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sust_pkg::CAP_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/sorted_unique_score_table.sv -----
// Sorted table of (key, score) entries, highest score first, keys unique.
// Channels: in_i carries one command word (action, key, score, position),
// out_o returns one result word per command, cfg_i writes the capacity
// register (always ready; write only while the block is idle).
// Commands: insert, remove by key, rank of key, read at a position.
// One command is worked at a time; in_i is ready only while no command is
// in progress. Read fetches its entry; rank scans the entries; remove scans,
// then shifts the entries below the hit up; insert scans, shifts the lower
// entries down and puts the new one; a refused insert (full) or a read past
// the count goes straight to the result. The entry memory has one write and
// one registered read port: scan reads, shift moves, one entry per cycle.
// Results sit in an output register; the next command is accepted while a
// result still waits, and a finished command holds in its last step while
// the receiver stalls.
// Reset empties the table (count zero) and sets capacity to 256 at once;
// the entry memory is not cleared, since only entries below the count are
// ever read.
module sorted_unique_score_table #(
  parameter int unsigned TABLE_DEPTH = sust_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = sust_pkg::KEY_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sust_cfg_if.sink  cfg_i,
  sust_req_if.sink  in_i,
  sust_rsp_if.source out_o
);

  import sust_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned EW = KW + SCORE_W;

  sust_state_e state_q, state_d;

  // Command word
  sust_action_e        act_q, act_d;
  logic [KW-1:0]       key_q, key_d;
  logic [SCORE_W-1:0]  score_q, score_d;

  // Table and sequencer state
  logic [CW-1:0]       count_q, count_d;
  logic [CAP_W-1:0]    cap_q;
  logic [CW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       sh_ptr_q, sh_ptr_d;
  logic [CW-1:0]       rem_q, rem_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pend_idx_q, pend_idx_d;
  logic                found_q, found_d;
  logic [AW-1:0]       hit_idx_q, hit_idx_d;
  logic [CW-1:0]       gt_q, gt_d;

  // Result under construction
  sust_status_e        res_status_q, res_status_d;
  logic [RANK_W-1:0]   res_rank_q, res_rank_d;
  logic [KEY_IN_W-1:0] res_key_q, res_key_d;
  logic [SCORE_W-1:0]  res_score_q, res_score_d;

  // Output register
  logic                ovalid_q, ovalid_d;
  sust_status_e        o_status_q, o_status_d;
  logic [RANK_W-1:0]   o_rank_q, o_rank_d;
  logic [KEY_IN_W-1:0] o_key_q, o_key_d;
  logic [SCORE_W-1:0]  o_score_q, o_score_d;
  logic [COUNT_W-1:0]  o_count_q, o_count_d;

  // Entry memory port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [KW-1:0] rd_key;
  logic [SCORE_W-1:0] rd_score;

  logic in_fire, is_full, read_ok, scan_issue, scan_done, shift_done, out_free;
  logic hit, score_gt;

  sust_ram #(
    .Width (EW),
    .Depth (TABLE_DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key   = ram_rdata[EW-1:SCORE_W];
  assign rd_score = ram_rdata[SCORE_W-1:0];

  // Handshakes
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !ovalid_q || out_o.ready;

  // Shared compare unit and sequencer conditions
  assign is_full    = (LW'(count_q) >= LW'(cap_q)) || (count_q == CW'(TABLE_DEPTH));
  assign read_ok    = LW'(in_i.position) < LW'(count_q);
  assign scan_issue = (state_q == S_SCAN) && (ptr_q != count_q);
  assign scan_done  = (state_q == S_SCAN) && (ptr_q == count_q) && !pend_q;
  assign shift_done = (state_q == S_SHIFT) && (rem_q == '0) && !pend_q;
  assign hit        = pend_q && (rd_key == key_q);
  assign score_gt   = pend_q && (rd_score > score_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.action)
            ACT_INSERT: state_d = is_full ? S_FINISH : S_SCAN;
            ACT_READ:   state_d = read_ok ? S_RDATA : S_FINISH;
            default:    state_d = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          case (act_q)
            ACT_INSERT: state_d = found_q ? S_FINISH : S_SHIFT;
            ACT_REMOVE: state_d = found_q ? S_SHIFT : S_FINISH;
            default:    state_d = S_FINISH;
          endcase
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_d = (act_q == ACT_INSERT) ? S_PUT : S_FINISH;
        end
      end
      S_PUT:    state_d = S_FINISH;
      S_RDATA:  state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    act_d        = act_q;
    key_d        = key_q;
    score_d      = score_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    sh_ptr_d     = sh_ptr_q;
    rem_d        = rem_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    gt_d         = gt_q;
    res_status_d = res_status_q;
    res_rank_d   = res_rank_q;
    res_key_d    = res_key_q;
    res_score_d  = res_score_q;
    ovalid_d     = ovalid_q && !out_o.ready;
    o_status_d   = o_status_q;
    o_rank_d     = o_rank_q;
    o_key_d      = o_key_q;
    o_score_d    = o_score_q;
    o_count_d    = o_count_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // Latch the command word and clear the result
          act_d        = sust_action_e'(in_i.action);
          key_d        = in_i.key[KW-1:0];
          score_d      = in_i.score;
          res_status_d = ST_OK;
          res_rank_d   = '0;
          res_key_d    = '0;
          res_score_d  = '0;
          ptr_d        = '0;
          found_d      = 1'b0;
          gt_d         = '0;
          case (in_i.action)
            ACT_INSERT: begin
              if (is_full) begin
                res_status_d = ST_FULL;
              end
            end
            ACT_READ: begin
              if (read_ok) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_i.position);
              end else begin
                res_status_d = ST_ABSENT;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read per cycle, compare the word read last cycle
        pend_d = scan_issue;
        if (scan_issue) begin
          ram_re     = 1'b1;
          ram_raddr  = ptr_q[AW-1:0];
          pend_idx_d = ptr_q[AW-1:0];
          ptr_d      = ptr_q + CW'(1);
        end
        if (hit && !found_q) begin
          found_d   = 1'b1;
          hit_idx_d = pend_idx_q;
        end
        if (score_gt) begin
          gt_d = gt_q + CW'(1);
        end
        if (scan_done) begin
          case (act_q)
            ACT_INSERT: begin
              if (found_q) begin
                res_status_d = ST_DUP;
              end else begin
                rem_d    = count_q - gt_q;
                sh_ptr_d = AW'(count_q - CW'(1));
              end
            end
            ACT_REMOVE: begin
              if (found_q) begin
                rem_d    = count_q - CW'(hit_idx_q) - CW'(1);
                sh_ptr_d = hit_idx_q + AW'(1);
              end else begin
                res_status_d = ST_ABSENT;
              end
            end
            default: begin
              if (found_q) begin
                res_rank_d = RANK_W'(CW'(hit_idx_q) + CW'(1));
              end else begin
                res_status_d = ST_ABSENT;
              end
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Move one entry per cycle: down for insert, up for remove
        pend_d = (rem_q != '0);
        if (rem_q != '0) begin
          ram_re     = 1'b1;
          ram_raddr  = sh_ptr_q;
          pend_idx_d = sh_ptr_q;
          rem_d      = rem_q - CW'(1);
          sh_ptr_d   = (act_q == ACT_INSERT) ? sh_ptr_q - AW'(1) : sh_ptr_q + AW'(1);
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = (act_q == ACT_INSERT) ? pend_idx_q + AW'(1) : pend_idx_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (shift_done && (act_q == ACT_REMOVE)) begin
          count_d = count_q - CW'(1);
        end
      end

      S_PUT: begin
        // Drop the new entry into the opened slot
        ram_we    = 1'b1;
        ram_waddr = gt_q[AW-1:0];
        ram_wdata = {key_q, score_q};
        count_d   = count_q + CW'(1);
      end

      S_RDATA: begin
        res_key_d   = KEY_IN_W'(rd_key);
        res_score_d = rd_score;
      end

      S_FINISH: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          ovalid_d   = 1'b1;
          o_status_d = res_status_q;
          o_rank_d   = res_rank_q;
          o_key_d    = res_key_q;
          o_score_d  = res_score_q;
          o_count_d  = COUNT_W'(count_q);
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cap_q    <= CAP_RESET;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        cap_q <= cfg_i.data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    key_q        <= key_d;
    score_q      <= score_d;
    ptr_q        <= ptr_d;
    sh_ptr_q     <= sh_ptr_d;
    rem_q        <= rem_d;
    pend_idx_q   <= pend_idx_d;
    found_q      <= found_d;
    hit_idx_q    <= hit_idx_d;
    gt_q         <= gt_d;
    res_status_q <= res_status_d;
    res_rank_q   <= res_rank_d;
    res_key_q    <= res_key_d;
    res_score_q  <= res_score_d;
    o_status_q   <= o_status_d;
    o_rank_q     <= o_rank_d;
    o_key_q      <= o_key_d;
    o_score_q    <= o_score_d;
    o_count_q    <= o_count_d;
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.status      = o_status_q;
  assign out_o.rank        = o_rank_q;
  assign out_o.entry_key   = o_key_q;
  assign out_o.entry_score = o_score_q;
  assign out_o.entry_count = o_count_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_PUT || $past(state_q) == S_SHIFT))
    else $error("entry count changed outside insert or remove");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SHIFT || state_q == S_PUT))
    else $error("entry memory written outside shift or put");

  a_put_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT) |-> (count_q < CW'(TABLE_DEPTH)))
    else $error("insert into a full table");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> ($past(state_q) == S_FINISH))
    else $error("result word raised outside finish");

endmodule

// ----- hdl/sust_ram.sv -----
module sust_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
